[rtl/core/edc_pkg.sv]
// Shared constants and types of the edit distance engine.
package edc_pkg;

  localparam int MAX_LEN = 64;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int DIST_W  = 7;
  localparam int SYM_W   = 8;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    TOK_NONE   = 2'd0,
    TOK_LOAD   = 2'd1,
    TOK_QUERY  = 2'd2,
    TOK_FINISH = 2'd3
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t          kind;
    logic [SYM_W-1:0]   sym;
    logic [DIST_W-1:0]  diag;
    logic [DIST_W-1:0]  left;
    logic               ovf;
  } tok_t;

endpackage

[rtl/core/edc_cell.sv]
// One reference position of the edit distance chain: stored byte, row score, token stage.
module edc_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [edc_pkg::DIST_W-1:0] init_score,
  input  edc_pkg::tok_t              tok_in,
  output edc_pkg::tok_t              tok_out
);

  logic                       valid;
  logic [edc_pkg::SYM_W-1:0]  ch;
  logic [edc_pkg::DIST_W-1:0] score;

  logic                       valid_next;
  logic [edc_pkg::SYM_W-1:0]  ch_next;
  logic [edc_pkg::DIST_W-1:0] score_next;
  edc_pkg::tok_t              tok_next;
  logic [edc_pkg::DIST_W-1:0] min_du;
  logic [edc_pkg::DIST_W-1:0] min_all;
  logic [edc_pkg::DIST_W-1:0] fresh;

  always_comb begin
    min_du  = (tok_in.diag < score) ? tok_in.diag : score;
    min_all = (min_du < tok_in.left) ? min_du : tok_in.left;
    fresh   = (ch == tok_in.sym) ? tok_in.diag : min_all + edc_pkg::DIST_W'(1);
  end

  always_comb begin
    valid_next = valid;
    ch_next    = ch;
    score_next = score;
    tok_next   = tok_in;
    case (tok_in.kind)
      edc_pkg::TOK_LOAD: begin
        if (!valid) begin
          valid_next    = 1'b1;
          ch_next       = tok_in.sym;
          tok_next.kind = edc_pkg::TOK_NONE;
        end
      end
      edc_pkg::TOK_QUERY: begin
        if (valid) begin
          score_next    = fresh;
          tok_next.diag = score;
          tok_next.left = fresh;
        end
      end
      edc_pkg::TOK_FINISH: begin
        if (valid) begin
          tok_next.left = score;
        end
        valid_next = 1'b0;
        score_next = init_score;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      score   <= init_score;
      tok_out <= '0;
    end else if (en) begin
      valid   <= valid_next;
      score   <= score_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch <= ch_next;
    end
  end

endmodule

[rtl/core/edit_distance_engine.sv]
// Levenshtein edit distance engine: input control, cell chain and result register.
// Takes one item per cycle; items travel the chain one cell per cycle; both hold while
// the chain stalls. A finish item passes all MAX_LEN = 64 cells, then the result register;
// the chain stalls only while a second result reaches its end before the first is taken.
// Reset (rst, synchronous) clears lengths, overflow flag and every cell to the initial row.
module edit_distance_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic [1:0] s_tuser,   // [1:0] action
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] distance, [7] zero
  output logic       m_tuser    // [0] overflow
);

  logic [edc_pkg::LEN_W-1:0] ref_len;
  logic [edc_pkg::LEN_W-1:0] qry_len;
  logic                      ovf;
  logic                      en;
  logic                      accept;
  edc_pkg::tok_t             head;
  edc_pkg::tok_t             chain [edc_pkg::MAX_LEN+1];
  edc_pkg::tok_t             tail;

  assign tail     = chain[edc_pkg::MAX_LEN];
  assign en       = !((tail.kind == edc_pkg::TOK_FINISH) && m_tvalid && !m_tready);
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    head      = '0;
    head.kind = edc_pkg::TOK_NONE;
    head.sym  = s_tdata;
    head.ovf  = ovf;
    if (accept) begin
      case (edc_pkg::action_t'(s_tuser))
        edc_pkg::ACT_LOAD: begin
          if (qry_len == '0 && ref_len != edc_pkg::LEN_W'(edc_pkg::MAX_LEN)) begin
            head.kind = edc_pkg::TOK_LOAD;
          end
        end
        edc_pkg::ACT_QUERY: begin
          if (qry_len != edc_pkg::LEN_W'(edc_pkg::MAX_LEN)) begin
            head.kind = edc_pkg::TOK_QUERY;
            head.diag = edc_pkg::DIST_W'(qry_len);
            head.left = edc_pkg::DIST_W'(qry_len + edc_pkg::LEN_W'(1));
          end
        end
        edc_pkg::ACT_FINISH: begin
          head.kind = edc_pkg::TOK_FINISH;
          head.left = edc_pkg::DIST_W'(qry_len);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_len <= '0;
      qry_len <= '0;
      ovf     <= 1'b0;
    end else if (accept) begin
      case (edc_pkg::action_t'(s_tuser))
        edc_pkg::ACT_LOAD: begin
          if (qry_len == '0) begin
            if (ref_len == edc_pkg::LEN_W'(edc_pkg::MAX_LEN)) begin
              ovf <= 1'b1;
            end else begin
              ref_len <= ref_len + edc_pkg::LEN_W'(1);
            end
          end
        end
        edc_pkg::ACT_QUERY: begin
          if (qry_len == edc_pkg::LEN_W'(edc_pkg::MAX_LEN)) begin
            ovf <= 1'b1;
          end else begin
            qry_len <= qry_len + edc_pkg::LEN_W'(1);
          end
        end
        edc_pkg::ACT_FINISH: begin
          ref_len <= '0;
          qry_len <= '0;
          ovf     <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign chain[0] = head;

  for (genvar j = 0; j < edc_pkg::MAX_LEN; j++) begin : g_cell
    edc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .init_score (edc_pkg::DIST_W'(j + 1)),
      .tok_in     (chain[j]),
      .tok_out    (chain[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en && tail.kind == edc_pkg::TOK_FINISH) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tail.kind == edc_pkg::TOK_FINISH) begin
      m_tdata <= {1'b0, tail.left};
      m_tuser <= tail.ovf;
    end
  end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the edit distance engine: stream stimulus, row predictor, checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import edc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = MAX_LEN + 10;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } dist_result_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic [1:0] s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tuser;

  edit_distance_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  dist_result_t      pending_distances[$];
  logic [SYM_W-1:0]  ref_chars[MAX_LEN];
  logic [DIST_W-1:0] score_row[MAX_LEN+1];
  logic [LEN_W-1:0]  ref_len;
  logic [LEN_W-1:0]  query_len;
  logic              ovf_seen;
  logic [SYM_W-1:0]  alphabet[3];

  bit idle_on;
  int err_count;
  int cycle_count;
  int sent_items;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_model();
    for (int j = 0; j <= MAX_LEN; j++) score_row[j] = DIST_W'(j);
    ref_len   = '0;
    query_len = '0;
    ovf_seen  = 1'b0;
  endfunction

  // Advance the predicted DP state by one accepted item.
  function automatic void predict_distance(logic [1:0] act, logic [SYM_W-1:0] sym);
    logic [DIST_W-1:0] diag;
    logic [DIST_W-1:0] up;
    logic [DIST_W-1:0] lowest;
    dist_result_t      r;
    case (act)
      ACT_LOAD: begin
        if (query_len == 0) begin
          if (ref_len >= MAX_LEN) begin
            ovf_seen = 1'b1;
          end else begin
            ref_chars[ref_len[LEN_W-2:0]] = sym;
            ref_len = ref_len + 1'b1;
          end
        end
      end
      ACT_QUERY: begin
        if (query_len >= MAX_LEN) begin
          ovf_seen = 1'b1;
        end else begin
          diag = score_row[0];
          score_row[0] = DIST_W'(query_len + 1);
          for (int j = 1; j <= ref_len; j++) begin
            up = score_row[j];
            if (ref_chars[j-1] == sym) begin
              score_row[j] = diag;
            end else begin
              lowest = (diag < up) ? diag : up;
              if (score_row[j-1] < lowest) lowest = score_row[j-1];
              score_row[j] = lowest + 1'b1;
            end
            diag = up;
          end
          query_len = query_len + 1'b1;
        end
      end
      ACT_FINISH: begin
        r.distance = score_row[ref_len];
        r.overflow = ovf_seen;
        pending_distances.push_back(r);
        clear_model();
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [1:0] act, logic [SYM_W-1:0] sym);
    while (idle_on && $urandom_range(99) < 18) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 2'($urandom);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    predict_distance(act, sym);
    sent_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_len();
    int p;
    p = $urandom_range(99);
    if (p < 80) return $urandom_range(10);
    if (p < 95) return $urandom_range(40, 11);
    return $urandom_range(MAX_LEN + 2, 41);
  endfunction

  function automatic logic [SYM_W-1:0] pick_sym(bit narrow);
    if (narrow) return alphabet[$urandom_range(2)];
    return SYM_W'($urandom);
  endfunction

  // One reference/query pair with random content and occasional noise.
  task automatic send_pair();
    int  rl;
    int  ql;
    bit  narrow;
    rl = pick_len();
    ql = pick_len();
    narrow = ($urandom_range(99) < 60);
    for (int k = 0; k < 3; k++) alphabet[k] = SYM_W'($urandom);
    for (int i = 0; i < rl; i++) begin
      if ($urandom_range(99) < 4) send_item(ACT_UNUSED, SYM_W'($urandom));
      send_item(ACT_LOAD, pick_sym(narrow));
    end
    for (int i = 0; i < ql; i++) begin
      if ($urandom_range(99) < 4) send_item(ACT_UNUSED, SYM_W'($urandom));
      if (i > 0 && $urandom_range(99) < 4) send_item(ACT_LOAD, SYM_W'($urandom));
      send_item(ACT_QUERY, pick_sym(narrow));
    end
    send_item(ACT_FINISH, SYM_W'($urandom));
  endtask

  task automatic test_directed();
    send_item(ACT_FINISH, 8'hFF);
    send_item(ACT_LOAD, 8'h00);
    send_item(ACT_LOAD, 8'hFF);
    send_item(ACT_FINISH, 8'h00);
    send_item(ACT_QUERY, 8'hFF);
    send_item(ACT_QUERY, 8'h00);
    send_item(ACT_QUERY, 8'hFF);
    send_item(ACT_FINISH, 8'hFF);
    send_item(ACT_UNUSED, 8'hFF);
    send_item(ACT_LOAD, "a");
    send_item(ACT_LOAD, "b");
    send_item(ACT_LOAD, "c");
    send_item(ACT_QUERY, "a");
    send_item(ACT_UNUSED, 8'h00);
    send_item(ACT_QUERY, "x");
    send_item(ACT_LOAD, "z");
    send_item(ACT_QUERY, "c");
    send_item(ACT_FINISH, 8'h55);
    send_item(ACT_LOAD, "a");
    send_item(ACT_LOAD, "b");
    send_item(ACT_QUERY, "b");
    send_item(ACT_QUERY, "a");
    send_item(ACT_QUERY, "b");
    send_item(ACT_FINISH, 8'hAA);
  endtask

  task automatic test_length_limits();
    for (int i = 0; i < MAX_LEN; i++) send_item(ACT_LOAD, 8'h55);
    for (int i = 0; i < MAX_LEN; i++) send_item(ACT_QUERY, 8'hAA);
    send_item(ACT_FINISH, 8'h00);
    for (int i = 0; i < MAX_LEN + 1; i++) send_item(ACT_LOAD, SYM_W'($urandom));
    for (int i = 0; i < 3; i++) send_item(ACT_QUERY, SYM_W'($urandom));
    send_item(ACT_FINISH, 8'h00);
    send_item(ACT_LOAD, 8'h11);
    send_item(ACT_LOAD, 8'h22);
    for (int i = 0; i < MAX_LEN + 1; i++) send_item(ACT_QUERY, 8'h22);
    send_item(ACT_FINISH, 8'h00);
  endtask

  task automatic test_pause_until_drained();
    for (int i = 0; i < 4; i++) send_pair();
    wait_drained();
    for (int i = 0; i < 4; i++) send_pair();
  endtask

  task automatic test_random_pairs(int count);
    int start;
    start = sent_items;
    while (sent_items - start < count) send_pair();
  endtask

  task automatic test_no_stalls(int count);
    idle_on = 1'b0;
    test_random_pairs(count);
    idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= idle_on ? ($urandom_range(99) >= 18) : 1'b1;
    end
  end

  always @(posedge clk) begin
    dist_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_distances.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: distance %0d overflow %0d", m_tdata[6:0], m_tuser);
      end else begin
        want = pending_distances.pop_front();
        if (m_tdata[6:0] !== want.distance || m_tuser !== want.overflow) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: distance exp %0d got %0d, overflow exp %0d got %0d",
                     want.distance, m_tdata[6:0], want.overflow, m_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    m_tready  = 1'b0;
    idle_on   = 1'b1;
    err_count = 0;
    cycle_count = 0;
    sent_items  = 0;
    clear_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_length_limits();
    test_pause_until_drained();
    test_random_pairs(1000);
    test_no_stalls(350);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_distances.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/edc_pkg.sv
rtl/core/edc_cell.sv
rtl/core/edit_distance_engine.sv
tb/testbench.sv
